### sv/psu_pkg.sv
// shared types and constants for the png scanline unfilter
`default_nettype none

package psu_pkg;

    localparam int BYTE_W   = 8;
    localparam int CFG_W    = 14;
    localparam int CFG_IDX_W = 1;
    localparam int HIST_N   = 8;
    localparam int HIST_W   = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_BYTES = 1'b0,
        CFG_BPP       = 1'b1
    } cfg_idx_t;

    localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
    localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
    localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] c;
    } nbr_t;

endpackage

`default_nettype wire

### sv/psu_ram.sv
// generic simple dual port ram with registered read
`default_nettype none

module psu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                      clk,
    input  wire logic                      we,
    input  wire logic [ADDR_W-1:0]         waddr,
    input  wire logic [WIDTH-1:0]          wdata,
    input  wire logic                      re,
    input  wire logic [ADDR_W-1:0]         raddr,
    output logic      [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/psu_predict.sv
// filter type decode and none, sub, up, average and paeth reconstruction
`default_nettype none

module psu_predict (
    input  wire logic [psu_pkg::BYTE_W-1:0] filt,
    input  wire logic [psu_pkg::BYTE_W-1:0] raw,
    input  wire psu_pkg::nbr_t              nbr,
    output logic      [psu_pkg::BYTE_W-1:0] recon,
    output logic                            bad
);

    logic [psu_pkg::BYTE_W:0]   sum_ab;
    logic [psu_pkg::BYTE_W:0]   dbl_c;
    logic [psu_pkg::BYTE_W:0]   pa;
    logic [psu_pkg::BYTE_W:0]   pb;
    logic [psu_pkg::BYTE_W:0]   pc;
    logic [psu_pkg::BYTE_W-1:0] paeth;
    logic [psu_pkg::BYTE_W-1:0] avg;

    always_comb
    begin
        sum_ab = {1'b0, nbr.a} + {1'b0, nbr.b};
        dbl_c  = {nbr.c, 1'b0};
        avg    = sum_ab[psu_pkg::BYTE_W:1];
        pa = (nbr.b >= nbr.c) ? {1'b0, nbr.b - nbr.c} : {1'b0, nbr.c - nbr.b};
        pb = (nbr.a >= nbr.c) ? {1'b0, nbr.a - nbr.c} : {1'b0, nbr.c - nbr.a};
        pc = (sum_ab >= dbl_c) ? (sum_ab - dbl_c) : (dbl_c - sum_ab);
        if (pa <= pb && pa <= pc)
        begin
            paeth = nbr.a;
        end
        else if (pb <= pc)
        begin
            paeth = nbr.b;
        end
        else
        begin
            paeth = nbr.c;
        end

        bad = 1'b0;
        case (filt)
            psu_pkg::FILT_NONE:  recon = raw;
            psu_pkg::FILT_SUB:   recon = raw + nbr.a;
            psu_pkg::FILT_UP:    recon = raw + nbr.b;
            psu_pkg::FILT_AVG:   recon = raw + avg;
            psu_pkg::FILT_PAETH: recon = raw + paeth;
            default:
            begin
                recon = raw;
                bad   = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

### sv/png_scanline_unfilter.sv
// top level of the png scanline unfilter
`default_nettype none

// Rebuilds filtered PNG scanlines at one stream word per clock, sustained unless
// the output stalls; a word passes the input register, then the result register.
// The rate is set by the single read and single write port of the line memory: a
// word's address is read as it is accepted, and the rebuilt byte is written back
// as it leaves the input register. Filter words produce no output word. The line
// memory needs no clearing pass; the first row of each image reads zeros above.
module png_scanline_unfilter #(
    parameter int MAX_ROW_BYTES = 8192
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [7:0]                   s_tdata,   // stream_byte
    input  wire logic                         s_tuser,   // start_image
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [7:0]                   m_tdata,   // pixel_byte
    output logic                              m_tlast,   // row_end
    output logic                              m_tuser,   // bad_filter
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [psu_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [psu_pkg::CFG_W-1:0]    cfg_data
);

    localparam int POS_W  = $clog2(MAX_ROW_BYTES + 1);
    localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
    localparam int BW     = psu_pkg::BYTE_W;

    logic [psu_pkg::CFG_W-1:0] row_bytes_reg;
    logic [3:0]                bpp_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              first_row_reg, first_row_next;
    logic [BW-1:0]     filt_reg, filt_next;

    logic              s1_valid_reg;
    logic              s1_is_filt_reg;
    logic              s1_first_reg;
    logic              s1_last_reg;
    logic [BW-1:0]     s1_byte_reg;
    logic [BW-1:0]     s1_filt_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic [BW-1:0]     left_reg [psu_pkg::HIST_N];
    logic [BW-1:0]     upleft_reg [psu_pkg::HIST_N];

    logic              s_acc;
    logic              s1_adv;
    logic              start_filt;
    logic [POS_W-1:0]  eff_len;
    logic [POS_W-1:0]  x_pos;
    logic              last_now;
    logic [psu_pkg::HIST_W-1:0] tap;
    logic [BW-1:0]     above_rd;
    psu_pkg::nbr_t     nbr;
    logic [BW-1:0]     recon;
    logic              bad;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= psu_pkg::CFG_W'(1);
            bpp_reg       <= 4'd1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                psu_pkg::CFG_ROW_BYTES: row_bytes_reg <= cfg_data;
                psu_pkg::CFG_BPP:       bpp_reg       <= cfg_data[3:0];
                default:                ;
            endcase
        end
    end

    always_comb
    begin
        if (row_bytes_reg == '0)
        begin
            eff_len = POS_W'(1);
        end
        else if (32'(row_bytes_reg) > 32'(MAX_ROW_BYTES))
        begin
            eff_len = POS_W'(MAX_ROW_BYTES);
        end
        else
        begin
            eff_len = POS_W'(row_bytes_reg);
        end

        if (bpp_reg == 4'd0)
        begin
            tap = '0;
        end
        else if (bpp_reg > 4'd8)
        begin
            tap = psu_pkg::HIST_W'(psu_pkg::HIST_N - 1);
        end
        else
        begin
            tap = psu_pkg::HIST_W'(bpp_reg - 4'd1);
        end
    end

    // handshake
    assign s1_adv   = s1_valid_reg && (s1_is_filt_reg || !m_tvalid || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_acc    = s_tvalid && s_tready;

    // row position tracking at accept
    always_comb
    begin
        start_filt = s_tuser || (pos_reg == '0);
        x_pos      = pos_reg - POS_W'(1);
        if (x_pos >= eff_len)
        begin
            x_pos = eff_len - POS_W'(1);
        end
        last_now = (pos_reg >= eff_len);

        pos_next       = pos_reg;
        first_row_next = first_row_reg;
        filt_next      = filt_reg;
        if (s_acc)
        begin
            if (start_filt)
            begin
                pos_next  = POS_W'(1);
                filt_next = s_tdata;
                if (s_tuser)
                begin
                    first_row_next = 1'b1;
                end
            end
            else if (last_now)
            begin
                pos_next       = '0;
                first_row_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            first_row_reg <= 1'b1;
            filt_reg      <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            first_row_reg <= first_row_next;
            filt_reg      <= filt_next;
            if (s_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            s1_is_filt_reg <= start_filt;
            s1_first_reg   <= first_row_reg;
            s1_last_reg    <= last_now;
            s1_byte_reg    <= s_tdata;
            s1_filt_reg    <= filt_reg;
            s1_addr_reg    <= x_pos[ADDR_W-1:0];
        end
    end

    psu_ram #(
        .WIDTH (BW),
        .DEPTH (MAX_ROW_BYTES)
    ) u_above (
        .clk   (clk),
        .we    (s1_adv && !s1_is_filt_reg),
        .waddr (s1_addr_reg),
        .wdata (recon),
        .re    (s_acc),
        .raddr (x_pos[ADDR_W-1:0]),
        .rdata (above_rd)
    );

    always_comb
    begin
        nbr.a = left_reg[tap];
        nbr.b = s1_first_reg ? '0 : above_rd;
        nbr.c = upleft_reg[tap];
    end

    psu_predict u_predict (
        .filt  (s1_filt_reg),
        .raw   (s1_byte_reg),
        .nbr   (nbr),
        .recon (recon),
        .bad   (bad)
    );

    // neighbor history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < psu_pkg::HIST_N; i++)
            begin
                left_reg[i]   <= '0;
                upleft_reg[i] <= '0;
            end
        end
        else if (s1_adv)
        begin
            if (s1_is_filt_reg)
            begin
                for (int i = 0; i < psu_pkg::HIST_N; i++)
                begin
                    left_reg[i]   <= '0;
                    upleft_reg[i] <= '0;
                end
            end
            else
            begin
                for (int i = psu_pkg::HIST_N - 1; i > 0; i--)
                begin
                    left_reg[i]   <= left_reg[i-1];
                    upleft_reg[i] <= upleft_reg[i-1];
                end
                left_reg[0]   <= recon;
                upleft_reg[0] <= nbr.b;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (s1_adv && !s1_is_filt_reg)
        begin
            m_tvalid <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && !s1_is_filt_reg)
        begin
            m_tdata <= recon;
            m_tlast <= s1_last_reg;
            m_tuser <= bad;
        end
    end

    // checks
    a_filter_starts_row: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && start_filt |=> pos_reg == POS_W'(1))
        else $error("filter word did not start a row");

    a_last_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && !start_filt && last_now |=> pos_reg == '0 && !first_row_reg)
        else $error("last data word did not end the row");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_is_filt_reg && m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while pipeline is blocked");

endmodule

`default_nettype wire
